// File: rtl/core/pipw_pkg.sv
package pipw_pkg;

  // Fixed field widths of the ports
  localparam int FIELD_COORD_W = 32;
  localparam int FIELD_IDX_W   = 6;
  localparam int CNT_W         = 7;

  // Storage and arithmetic sizing
  localparam int MAX_VERTICES = 64;
  localparam int COORD_W      = 32;
  localparam int AW           = $clog2(MAX_VERTICES);
  localparam int NW           = $clog2(MAX_VERTICES + 1);
  localparam int WN_W         = AW + 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COORD_W:0]   diff_t;
  typedef logic        [COORD_W-1:0] mag_t;
  typedef logic        [2*COORD_W-1:0] prod_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vertex_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FIRST = 7'b0000010,
    S_DIFF  = 7'b0000100,
    S_MUL1  = 7'b0001000,
    S_MUL2  = 7'b0010000,
    S_LAST  = 7'b0100000,
    S_SPARE = 7'b1000000
  } state_t;

  function automatic mag_t mag_of(diff_t d);
    diff_t neg;
    neg = -d;
    return d[COORD_W] ? neg[COORD_W-1:0] : d[COORD_W-1:0];
  endfunction

endpackage

// File: rtl/core/pipw_vertex_store.sv
module pipw_vertex_store (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [pipw_pkg::AW-1:0] wr_addr,
  input  pipw_pkg::vertex_t      wr_data,
  input  logic [pipw_pkg::AW-1:0] rd_addr,
  output pipw_pkg::vertex_t      rd_data
);
  import pipw_pkg::*;

  vertex_t mem [MAX_VERTICES];
  vertex_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/point_in_polygon_winding_test.sv
// Channel   | Direction | Handshake             | Payload
// ----------+-----------+-----------------------+------------------------------------------
// in        | input     | in_valid / in_ready   | in_command, in_vertex_index, in_coord_x/y
// out       | output    | out_valid / out_ready | out_inside_res
// cfg       | input     | cfg_we (no wait)      | cfg_wdata (vertex_count)
//
// A load request gives no result. A query request passes through a fetch step
// (skipped for an empty ring; n = vertex_count clamped to the store depth), then per
// edge a difference step and a left- and a right-product step on the shared 32x32
// multiplier, then a closing step.
// Reset is synchronous: vertex_count goes to 3; the vertex store is not cleared.
// A waiting result holds the next query in its final step; loads still pass.
module point_in_polygon_winding_test (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_we,
  input  logic        [pipw_pkg::CNT_W-1:0]         cfg_wdata,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic                                     in_command,
  input  logic        [pipw_pkg::FIELD_IDX_W-1:0]   in_vertex_index,
  input  logic signed [pipw_pkg::FIELD_COORD_W-1:0] in_coord_x,
  input  logic signed [pipw_pkg::FIELD_COORD_W-1:0] in_coord_y,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic                                     out_inside_res
);
  import pipw_pkg::*;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r;

  // Query point, edge start and the ring's first vertex
  coord_t px_r, py_r, ax_r, ay_r, v0x_r, v0y_r;
  logic [NW-1:0] n_r, e_r;

  // Per-edge results of the difference step
  mag_t ex_m_r, ey_m_r, qx_m_r, qy_m_r;
  logic ln_r, rn_r, within_r, up_r, dn_r;
  prod_t pl_r, pr_r;

  // Running decision
  logic pend_r, hit_r, hit_nxt;
  logic signed [WN_W-1:0] wn_r, wn_nxt;

  logic out_valid_r, out_res_r;

  // Input decode
  coord_t in_x, in_y;
  logic [NW-1:0] n_in;
  logic accept, is_load, is_query;

  assign in_x     = in_coord_x[COORD_W-1:0];
  assign in_y     = in_coord_y[COORD_W-1:0];
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign is_load  = accept && !in_command;
  assign is_query = accept && in_command;
  assign n_in     = (int'(count_r) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(count_r);

  // Vertex store: read every cycle, data registered and valid in the next cycle
  logic [AW-1:0] rd_addr;
  logic [NW-1:0] e_inc;
  logic          wr_en;
  vertex_t       wr_vtx, rd_vtx;

  assign e_inc   = e_r + NW'(1);
  assign rd_addr = (state_r == S_IDLE) ? '0 : e_inc[AW-1:0];
  assign wr_en   = is_load && (int'(in_vertex_index) < MAX_VERTICES);
  assign wr_vtx  = '{x: in_x, y: in_y};

  pipw_vertex_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_vertex_index)),
    .wr_data (wr_vtx),
    .rd_addr (rd_addr),
    .rd_data (rd_vtx)
  );

  // Edge end: the closing edge returns to vertex zero
  coord_t bx, by;
  logic   last_edge;
  diff_t  ex, ey, qx, qy;
  logic   within_nxt;

  assign last_edge = (e_r == n_r - NW'(1));
  assign bx = last_edge ? v0x_r : rd_vtx.x;
  assign by = last_edge ? v0y_r : rd_vtx.y;

  assign ex = diff_t'(bx)   - diff_t'(ax_r);
  assign ey = diff_t'(by)   - diff_t'(ay_r);
  assign qx = diff_t'(px_r) - diff_t'(ax_r);
  assign qy = diff_t'(py_r) - diff_t'(ay_r);

  assign within_nxt = ((ax_r <= px_r && px_r <= bx) || (bx <= px_r && px_r <= ax_r)) &&
                      ((ay_r <= py_r && py_r <= by) || (by <= py_r && py_r <= ay_r));

  // Shared multiplier: left product first, right product second
  mag_t  mul_a, mul_b;
  prod_t prod;

  assign mul_a = (state_r == S_MUL1) ? ex_m_r : qx_m_r;
  assign mul_b = (state_r == S_MUL1) ? qy_m_r : ey_m_r;
  assign prod  = prod_t'(mul_a) * prod_t'(mul_b);

  // Sign of the previous edge's cross product from two signed magnitudes
  logic s_pos, s_neg, s_zero, gt, eq;

  assign gt = (pl_r > pr_r);
  assign eq = (pl_r == pr_r);

  always_comb begin
    if (ln_r != rn_r) begin
      s_pos = rn_r;
      s_neg = ln_r;
    end else if (eq) begin
      s_pos = 1'b0;
      s_neg = 1'b0;
    end else if (!ln_r) begin
      s_pos = gt;
      s_neg = !gt;
    end else begin
      s_pos = !gt;
      s_neg = gt;
    end
    s_zero = !s_pos && !s_neg;
  end

  always_comb begin
    hit_nxt = hit_r || (pend_r && s_zero && within_r);
    wn_nxt  = wn_r;
    if (pend_r && up_r && s_pos) begin
      wn_nxt = wn_r + WN_W'(1);
    end else if (pend_r && dn_r && s_neg) begin
      wn_nxt = wn_r - WN_W'(1);
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (is_query) begin
          state_nxt = (n_in == '0) ? S_LAST : S_FIRST;
        end
      end
      S_FIRST: state_nxt = S_DIFF;
      S_DIFF:  state_nxt = S_MUL1;
      S_MUL1:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = (e_r == n_r) ? S_LAST : S_DIFF;
      S_LAST: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= CNT_W'(3);
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      wn_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
      // Drop a taken result unless the final step refills the register
      if (out_valid_r && out_ready && state_r != S_LAST) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (is_query) begin
            pend_r <= 1'b0;
            hit_r  <= 1'b0;
            wn_r   <= '0;
          end
        end
        S_DIFF: begin
          // Retire the previous edge, start this one
          pend_r <= 1'b1;
          hit_r  <= hit_nxt;
          wn_r   <= wn_nxt;
        end
        S_LAST: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (is_query) begin
          px_r <= in_x;
          py_r <= in_y;
          n_r  <= n_in;
          e_r  <= '0;
        end
      end
      S_FIRST: begin
        ax_r  <= rd_vtx.x;
        ay_r  <= rd_vtx.y;
        v0x_r <= rd_vtx.x;
        v0y_r <= rd_vtx.y;
      end
      S_DIFF: begin
        ex_m_r   <= mag_of(ex);
        ey_m_r   <= mag_of(ey);
        qx_m_r   <= mag_of(qx);
        qy_m_r   <= mag_of(qy);
        ln_r     <= (ex[COORD_W] ^ qy[COORD_W]) && (ex != '0) && (qy != '0);
        rn_r     <= (qx[COORD_W] ^ ey[COORD_W]) && (qx != '0) && (ey != '0);
        within_r <= within_nxt;
        up_r     <= (ay_r <= py_r) && (by > py_r);
        dn_r     <= (ay_r > py_r) && (by <= py_r);
        ax_r     <= bx;
        ay_r     <= by;
        e_r      <= e_inc;
      end
      S_MUL1: pl_r <= prod;
      S_MUL2: pr_r <= prod;
      S_LAST: begin
        if (!out_valid_r || out_ready) begin
          out_res_r <= hit_nxt || (wn_nxt != '0);
        end
      end
      default: ;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_res_r;

endmodule

// File: rtl/core/pipw_checker.sv
module pipw_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_command,
  input logic out_valid,
  input logic out_ready,
  input logic out_inside_res
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_inside_res))
    else $error("result changed while stalled");

  // Drop the result after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A query never answers in the next cycle
  a_query_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command && !out_valid |=> !out_valid)
    else $error("query answered too early");

  // A query makes the block busy
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command |=> !in_ready)
    else $error("ready during a query");

  // A load keeps the block ready
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_command |=> in_ready)
    else $error("ready dropped after a load");

endmodule

bind point_in_polygon_winding_test pipw_checker u_pipw_checker (.*);
